FILE: rtl/gtr_pkg.sv
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared types and constants for the glyph text renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package gtr_pkg;

  // glyph width is fixed by the 8-bit row mask
  localparam int GLYPH_COLS = 8;

  localparam int FRAME_W  = 48;
  localparam int PITCH_W  = 16;
  localparam int CURSOR_W = 16;
  localparam int COLOUR_W = 32;
  localparam int ADDR_W   = 64;
  localparam int FIDX_W   = 12;
  localparam int GBASE_W  = 16;
  // pixel offset: 16-bit column plus 17-bit row times 16-bit pitch
  localparam int PIX_W    = 34;
  localparam int QDEPTH   = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_STRIDE = 2'd3;

  localparam logic [PITCH_W-1:0] LINE_PITCH_RST   = 16'd1024;
  localparam logic [PITCH_W-1:0] LINE_WIDTH_RST   = 16'd1024;
  localparam logic [7:0]         GLYPH_STRIDE_RST = 8'd16;

  // input kind codes
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_DRAW = 2'd1;
  localparam logic [1:0] KIND_EOL  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_DRAW = 2'd1,
    OP_EOL  = 2'd2
  } gtr_op_t;

  // classified item: addr is the font index for a load, the glyph base for a draw
  typedef struct packed {
    gtr_op_t              op;
    logic [GBASE_W-1:0]   addr;
    logic [7:0]           data;
    logic [COLOUR_W-1:0]  colour;
  } gtr_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame_base;
    logic [PITCH_W-1:0]  line_pitch;
    logic [PITCH_W-1:0]  line_width;
  } gtr_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/gtr_front.sv
// ----------------------------------------------------------------------------
// gtr_front
// Accepts input beats, drops undefined kinds and works out the glyph base.
// ----------------------------------------------------------------------------
`default_nettype none

module gtr_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    kind,
  input  wire logic [gtr_pkg::FIDX_W-1:0]    font_index,
  input  wire logic [7:0]                    font_byte,
  input  wire logic [7:0]                    char_code,
  input  wire logic [gtr_pkg::COLOUR_W-1:0]  colour,
  input  wire logic [7:0]                    glyph_stride,
  output logic                               push,
  output gtr_pkg::gtr_item_t                 push_item,
  input  wire logic                          q_full
);
  import gtr_pkg::*;

  logic      f_valid;
  gtr_item_t f_item;
  gtr_item_t dec_item;
  logic      dec_keep;

  always_comb begin
    dec_item        = '0;
    dec_item.data   = font_byte;
    dec_item.colour = colour;
    dec_keep        = 1'b1;
    unique case (kind)
      KIND_LOAD: begin
        dec_item.op   = OP_LOAD;
        dec_item.addr = GBASE_W'(font_index);
      end
      KIND_DRAW: begin
        dec_item.op   = OP_DRAW;
        dec_item.addr = GBASE_W'(char_code) * GBASE_W'(glyph_stride);
      end
      KIND_EOL: begin
        dec_item.op = OP_EOL;
      end
      default: begin
        dec_keep = 1'b0;
      end
    endcase
  end

  assign push      = f_valid && !q_full;
  assign push_item = f_item;
  assign in_ready  = !f_valid || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_valid <= dec_keep;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_item <= dec_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gtr_queue.sv
// ----------------------------------------------------------------------------
// gtr_queue
// Short item queue between the front and the row sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module gtr_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire gtr_pkg::gtr_item_t  push_item,
  output logic                     full,
  input  wire logic                pop,
  output gtr_pkg::gtr_item_t       head,
  output logic                     empty
);
  import gtr_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  gtr_item_t            slots [QDEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [PTR_W:0]       count;

  assign full  = (count == (PTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gtr_back.sv
// ----------------------------------------------------------------------------
// gtr_back
// Font store, cursor and row sequencer; emits one glyph row write per cycle while drawing and the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module gtr_back #(
  parameter int FONT_BYTES = 4096,
  parameter int GLYPH_ROWS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire gtr_pkg::gtr_cfg_t             cfg,
  input  wire gtr_pkg::gtr_item_t            head,
  input  wire logic                          empty,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [gtr_pkg::ADDR_W-1:0]         row_address,
  output logic [7:0]                         pixel_mask,
  output logic [gtr_pkg::COLOUR_W-1:0]       pixel_value,
  output logic                               last_row
);
  import gtr_pkg::*;

  localparam int FA_W = $clog2(FONT_BYTES);
  localparam int RW   = $clog2(GLYPH_ROWS);
  localparam int GA_W = GBASE_W + 1;
  localparam logic [GA_W-1:0] FONT_LIM = GA_W'(FONT_BYTES);
  localparam logic [RW-1:0]   ROW_LAST = RW'(GLYPH_ROWS - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_ROWS  = 3'b100
  } state_t;

  state_t                state;
  logic [CURSOR_W-1:0]   cursor_col;
  logic [CURSOR_W-1:0]   cursor_row;
  logic [RW-1:0]         row;
  logic [GA_W-1:0]       gaddr;
  logic [PIX_W-1:0]      pix;
  logic [COLOUR_W-1:0]   d_colour;

  logic [7:0]            mem [FONT_BYTES];
  logic [7:0]            mem_q;
  logic                  mem_we;

  logic                  s1_valid;
  logic [PIX_W-1:0]      s1_pix;
  logic                  s1_last;
  logic                  s1_oob;
  logic [COLOUR_W-1:0]   s1_colour;

  logic                  advance;
  logic                  issue;
  logic [CURSOR_W:0]     nl_row;
  logic [CURSOR_W-1:0]   nl_row_sat;
  logic [CURSOR_W:0]     next_col;
  logic                  wrap;

  assign advance = !out_valid || out_ready;
  assign issue   = (state == ST_ROWS) && advance;
  assign pop     = (state == ST_IDLE) && !empty;
  assign mem_we  = pop && (head.op == OP_LOAD) && ({1'b0, head.addr} < FONT_LIM);

  // new line saturates the vertical cursor
  assign nl_row     = {1'b0, cursor_row} + (CURSOR_W+1)'(GLYPH_ROWS);
  assign nl_row_sat = nl_row[CURSOR_W] ? '1 : nl_row[CURSOR_W-1:0];
  assign next_col   = {1'b0, cursor_col} + (CURSOR_W+1)'(GLYPH_COLS);
  assign wrap       = ({1'b0, next_col} + (CURSOR_W+2)'(GLYPH_COLS))
                      > {2'b00, cfg.line_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cursor_col <= '0;
      cursor_row <= '0;
      row        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            unique case (head.op)
              OP_DRAW: state <= ST_SETUP;
              OP_EOL: begin
                cursor_col <= '0;
                cursor_row <= nl_row_sat;
              end
              default: ;
            endcase
          end
        end
        ST_SETUP: begin
          row   <= '0;
          state <= ST_ROWS;
        end
        ST_ROWS: begin
          if (advance) begin
            row <= row + 1'b1;
            if (row == ROW_LAST) begin
              state <= ST_IDLE;
              if (wrap) begin
                cursor_col <= '0;
                cursor_row <= nl_row_sat;
              end else begin
                cursor_col <= next_col[CURSOR_W-1:0];
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // draw datapath
  always_ff @(posedge clk) begin
    if (pop && head.op == OP_DRAW) begin
      gaddr    <= {1'b0, head.addr};
      d_colour <= head.colour;
    end
    if (state == ST_SETUP) begin
      pix <= PIX_W'(cursor_row) * PIX_W'(cfg.line_pitch) + PIX_W'(cursor_col);
    end else if (issue) begin
      pix   <= pix + PIX_W'(cfg.line_pitch);
      gaddr <= gaddr + 1'b1;
    end
  end

  // font store, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head.addr[FA_W-1:0]] <= head.data;
    end
    if (advance) begin
      mem_q <= mem[gaddr[FA_W-1:0]];
    end
  end

  // row issue stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= issue;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_pix    <= pix;
      s1_last   <= (row == ROW_LAST);
      s1_oob    <= (gaddr >= FONT_LIM);
      s1_colour <= d_colour;
    end
    if (advance && s1_valid) begin
      row_address <= ADDR_W'({1'b0, cfg.frame_base} + (FRAME_W+1)'({s1_pix, 2'b00}));
      pixel_mask  <= s1_oob ? 8'h00 : mem_q;
      pixel_value <= s1_colour;
      last_row    <= s1_last;
    end
  end

  a_col_aligned: assert property (@(posedge clk) disable iff (rst)
    cursor_col[2:0] == 3'b000)
    else $error("cursor column off glyph grid");

  a_setup_to_rows: assert property (@(posedge clk) disable iff (rst)
    state == ST_SETUP |=> state == ST_ROWS && row == '0)
    else $error("setup did not start at first row");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_pix))
    else $error("issued row lost under stall");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == ST_IDLE && !empty)
    else $error("queue popped while sequencer busy");

endmodule

`default_nettype wire

FILE: rtl/glyph_text_renderer.sv
// Sequencing: a character passes the idle, setup and row states of the row sequencer,
//   one row per cycle through the single font store read port while the receiver is
//   ready; load and end-of-line items are handled in the idle state as they are popped.
//   No new item is popped until the last row of a character has been issued.
// Reset: cursor and handshake state clear at once; the font store has no clearing pass
//   and holds undefined data until loaded.
// ----------------------------------------------------------------------------
// glyph_text_renderer
// Draws 8-pixel-wide bitmap glyphs as row writes into a 32-bit framebuffer.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_text_renderer #(
  parameter int FONT_BYTES = 4096,
  parameter int GLYPH_ROWS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [gtr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gtr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      kind,
  input  wire logic [gtr_pkg::FIDX_W-1:0]      font_index,
  input  wire logic [7:0]                      font_byte,
  input  wire logic [7:0]                      char_code,
  input  wire logic [gtr_pkg::COLOUR_W-1:0]    colour,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [gtr_pkg::ADDR_W-1:0]           row_address,
  output logic [7:0]                           pixel_mask,
  output logic [gtr_pkg::COLOUR_W-1:0]         pixel_value,
  output logic                                 last_row
);
  import gtr_pkg::*;

  gtr_cfg_t   cfg;
  logic [7:0] glyph_stride;
  logic       push;
  gtr_item_t  push_item;
  logic       q_full;
  logic       pop;
  gtr_item_t  head;
  logic       q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_base <= '0;
      cfg.line_pitch <= LINE_PITCH_RST;
      cfg.line_width <= LINE_WIDTH_RST;
      glyph_stride   <= GLYPH_STRIDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_BASE:   cfg.frame_base <= cfg_data[FRAME_W-1:0];
        REG_LINE_PITCH:   cfg.line_pitch <= cfg_data[PITCH_W-1:0];
        REG_LINE_WIDTH:   cfg.line_width <= cfg_data[PITCH_W-1:0];
        REG_GLYPH_STRIDE: glyph_stride   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  gtr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .font_index   (font_index),
    .font_byte    (font_byte),
    .char_code    (char_code),
    .colour       (colour),
    .glyph_stride (glyph_stride),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  gtr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  gtr_back #(
    .FONT_BYTES (FONT_BYTES),
    .GLYPH_ROWS (GLYPH_ROWS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .empty       (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .row_address (row_address),
    .pixel_mask  (pixel_mask),
    .pixel_value (pixel_value),
    .last_row    (last_row)
  );

endmodule

`default_nettype wire

FILE: test/tb_glyph_text_renderer.sv
// ----------------------------------------------------------------------------
// tb_glyph_text_renderer
// Self-checking bench for the glyph text renderer. It loads glyphs into the
// font store, draws characters and ends lines under a series of framebuffer
// and font layouts. A scoreboard predicts every row write and checks it.
// ----------------------------------------------------------------------------
module tb_glyph_text_renderer;
  timeunit 1ns;
  timeprecision 1ps;

  import gtr_pkg::*;

  localparam int FONT_BYTES = 4096;
  localparam int GLYPH_ROWS = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 38;
  localparam int TAIL_NEWLINES = 6;
  // kind code with no meaning, the block drops it
  localparam logic [1:0] KIND_BAD = 2'd3;

  typedef struct {
    logic [ADDR_W-1:0]   addr;
    logic [7:0]          mask;
    logic [COLOUR_W-1:0] value;
    logic                last;
  } row_write_t;

  class render_scoreboard;
    logic [FRAME_W-1:0]  frame_base;
    logic [PITCH_W-1:0]  line_pitch;
    logic [PITCH_W-1:0]  line_width;
    logic [7:0]          glyph_stride;
    logic [CURSOR_W-1:0] cursor_col;
    logic [CURSOR_W-1:0] cursor_row;
    logic [7:0]          font_mem [FONT_BYTES];
    row_write_t          pending_rows [$];
    int                  errors;

    function new();
      frame_base = '0;
      line_pitch = LINE_PITCH_RST;
      line_width = LINE_WIDTH_RST;
      glyph_stride = GLYPH_STRIDE_RST;
      cursor_col = '0;
      cursor_row = '0;
      errors = 0;
    endfunction

    function void flag(string msg);
      errors++;
      $display("%s", msg);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_BASE:   frame_base = data[FRAME_W-1:0];
        REG_LINE_PITCH:   line_pitch = data[PITCH_W-1:0];
        REG_LINE_WIDTH:   line_width = data[PITCH_W-1:0];
        REG_GLYPH_STRIDE: glyph_stride = data[7:0];
        default: ;
      endcase
    endfunction

    // vertical cursor sticks at the top of its range
    function void new_line();
      int r;
      r = int'(cursor_row) + GLYPH_ROWS;
      cursor_col = '0;
      cursor_row = (r > 16'hFFFF) ? 16'hFFFF : 16'(r);
    endfunction

    function void note_item(logic [1:0] k, logic [FIDX_W-1:0] fidx, logic [7:0] fbyte,
                            logic [7:0] code, logic [COLOUR_W-1:0] col);
      int base;
      int nxt;
      logic [63:0] y;
      logic [63:0] pix;
      row_write_t w;
      case (k)
        KIND_LOAD: font_mem[fidx] = fbyte;
        KIND_EOL:  new_line();
        KIND_DRAW: begin
          base = int'(code) * int'(glyph_stride);
          for (int r = 0; r < GLYPH_ROWS; r++) begin
            y = 64'(cursor_row) + 64'(r);
            pix = 64'(cursor_col) + y * 64'(line_pitch);
            w.addr = 64'(frame_base) + pix * 64'd4;
            // glyph rows past the end of the store read as blank
            w.mask = (base + r < FONT_BYTES) ? font_mem[base + r] : 8'h00;
            w.value = col;
            w.last = (r == GLYPH_ROWS - 1);
            pending_rows.push_back(w);
          end
          nxt = int'(cursor_col) + GLYPH_COLS;
          if (nxt + GLYPH_COLS > int'(line_width)) new_line();
          else cursor_col = 16'(nxt);
        end
        default: ;
      endcase
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want)
        flag($sformatf("%0t: %s expected %h, got %h", $time, field, want, got));
    endfunction

    function void check_row(logic [ADDR_W-1:0] addr, logic [7:0] mask,
                            logic [COLOUR_W-1:0] value, logic last);
      row_write_t w;
      if (pending_rows.size() == 0) begin
        flag($sformatf("%0t: row write with none expected: expected nothing, got addr %h",
                       $time, addr));
      end else begin
        w = pending_rows.pop_front();
        compare("row_address", w.addr, addr);
        compare("pixel_mask", 64'(w.mask), 64'(mask));
        compare("pixel_value", 64'(w.value), 64'(value));
        compare("last_row", 64'(w.last), 64'(last));
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            kind = KIND_LOAD;
  logic [FIDX_W-1:0]     font_index = '0;
  logic [7:0]            font_byte = '0;
  logic [7:0]            char_code = '0;
  logic [COLOUR_W-1:0]   colour = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ADDR_W-1:0]     row_address;
  logic [7:0]            pixel_mask;
  logic [COLOUR_W-1:0]   pixel_value;
  logic                  last_row;

  render_scoreboard sb;
  bit               idle_on = 1'b1;
  bit               font_loaded [FONT_BYTES];
  int               stall_left = 0;
  int               quiet_cycles = 0;
  int               items_sent = 0;
  logic [7:0]       palette [4];

  glyph_text_renderer #(
    .FONT_BYTES(FONT_BYTES),
    .GLYPH_ROWS(GLYPH_ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .font_index(font_index),
    .font_byte(font_byte),
    .char_code(char_code),
    .colour(colour),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .row_address(row_address),
    .pixel_mask(pixel_mask),
    .pixel_value(pixel_value),
    .last_row(last_row)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stalls come in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_item(kind, font_index, font_byte, char_code, colour);
      if (out_valid && out_ready)
        sb.check_row(row_address, pixel_mask, pixel_value, last_row);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  task automatic send_item(input logic [1:0] k, input logic [FIDX_W-1:0] fi,
                           input logic [7:0] fb, input logic [7:0] cc,
                           input logic [COLOUR_W-1:0] col);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    font_index <= fi;
    font_byte <= fb;
    char_code <= cc;
    colour <= col;
    do @(posedge clk); while (!in_ready);
    if (k != KIND_BAD) items_sent++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [COLOUR_W-1:0] pick_colour();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_byte(input logic [FIDX_W-1:0] fi, input logic [7:0] fb);
    send_item(KIND_LOAD, fi, fb, 8'($urandom), $urandom);
    font_loaded[fi] = 1'b1;
  endtask

  // fill in any glyph row that was never loaded, then draw
  task automatic draw_char(input logic [7:0] cc, input logic [COLOUR_W-1:0] col);
    int base;
    int a;
    base = int'(cc) * int'(sb.glyph_stride);
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      a = base + r;
      if (a < FONT_BYTES && !font_loaded[a]) load_byte(FIDX_W'(a), pick_byte());
    end
    send_item(KIND_DRAW, FIDX_W'($urandom), 8'($urandom), cc, col);
  endtask

  // wait for a clock edge first so the last accepted beat is already in the scoreboard
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input logic [FRAME_W-1:0] fb, input logic [PITCH_W-1:0] lp,
                              input logic [PITCH_W-1:0] lw, input logic [7:0] gs);
    logic [CFG_IDX_W-1:0]  regs [4];
    logic [CFG_DATA_W-1:0] vals [4];
    regs = '{REG_FRAME_BASE, REG_LINE_PITCH, REG_LINE_WIDTH, REG_GLYPH_STRIDE};
    vals = '{CFG_DATA_W'(fb), CFG_DATA_W'(lp), CFG_DATA_W'(lw), CFG_DATA_W'(gs)};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int p);
    logic [FRAME_W-1:0] fb;
    logic [PITCH_W-1:0] lp;
    logic [PITCH_W-1:0] lw;
    logic [7:0]         gs;
    int                 goal;
    int                 pick;
    case (p % 3)
      0: fb = '0;
      1: fb = '1;
      default: fb = FRAME_W'({$urandom, $urandom});
    endcase
    case (p % 4)
      0: lp = '1;
      1: lp = '0;
      2: lp = PITCH_W'($urandom_range(1, 300));
      default: lp = PITCH_W'($urandom);
    endcase
    case (p % 5)
      0: lw = 16'd16;
      1: lw = '1;
      2: lw = '0;
      3: lw = PITCH_W'($urandom_range(8, 96));
      default: lw = PITCH_W'($urandom);
    endcase
    case (p % 4)
      0: gs = 8'd255;
      1: gs = 8'd0;
      2: gs = 8'd16;
      default: gs = 8'($urandom_range(1, 254));
    endcase
    settle();
    apply_config(fb, lp, lw, gs);
    idle_on = (p % 4 != 3);
    // a few glyphs reused so most draws do not need a fresh load
    palette[0] = 8'($urandom_range(0, 15));
    for (int i = 1; i < 4; i++) palette[i] = 8'($urandom);
    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 19);
      if (pick == 12 || pick == 13)
        send_item(KIND_EOL, FIDX_W'($urandom), 8'($urandom), 8'($urandom), $urandom);
      else if (pick == 14 || pick == 15)
        load_byte(FIDX_W'($urandom), pick_byte());
      else if (pick == 16)
        send_item(KIND_BAD, FIDX_W'($urandom), 8'($urandom), 8'($urandom), $urandom);
      else if ($urandom_range(0, 9) < 7)
        draw_char(palette[$urandom_range(0, 3)], pick_colour());
      else
        draw_char(8'($urandom), pick_colour());
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: one glyph under reset layout, colour extremes, ignored kind, new line
    draw_char(8'h00, 32'h0000_0000);
    draw_char(8'h00, 32'hFFFF_FFFF);
    send_item(KIND_BAD, '1, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_item(KIND_EOL, '0, 8'h00, 8'h00, 32'h0);
    draw_char(8'h00, 32'h1234_5678);
    settle();
    // glyph rows far beyond the store come out blank
    apply_config('1, 16'hFFFF, 16'd16, 8'd255);
    draw_char(8'hFF, 32'hA5A5_5A5A);
    draw_char(8'h00, 32'h5A5A_A5A5);

    for (int p = 0; p < RAND_PHASES; p++) random_phase(p);

    // new lines and wraps under a 40-pixel line width, no idling from here on
    settle();
    apply_config('1, 16'hFFFF, 16'd40, 8'd16);
    idle_on = 1'b0;
    for (int i = 0; i < TAIL_NEWLINES; i++) begin
      if (i % 2 == 0) draw_char(8'($urandom_range(0, 1)), pick_colour());
      send_item(KIND_EOL, FIDX_W'($urandom), 8'($urandom), 8'($urandom), $urandom);
    end
    for (int i = 0; i < 4; i++) draw_char(8'($urandom_range(0, 1)), pick_colour());
    send_item(KIND_EOL, '0, 8'h00, 8'h00, 32'h0);
    draw_char(8'h03, pick_colour());

    settle();
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
